// File: hdl/rgba_table_resampler_defines.svh
// Assertion macros for the RGBA table resampler
`ifndef RGBA_TABLE_RESAMPLER_DEFINES_SVH
`define RGBA_TABLE_RESAMPLER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RTR_ASSERT_IMPL(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define RTR_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define RTR_ASSERT_IMPL(label, clk, rst, a, c)
`define RTR_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// File: hdl/rtr_pkg.sv
// Package: types and codes for the RGBA table resampler
package rtr_pkg;
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_NEXT  = 1'b1;
   localparam logic [1:0] REG_SOURCE_SIZE = 2'd0;
   localparam logic [1:0] REG_TARGET_SIZE = 2'd1;
   typedef enum logic [3:0] {
      ST_IDLE, ST_MODE, ST_DIV, ST_READ, ST_ACC, ST_AVG, ST_FRAC, ST_MUL, ST_DONE
   } state_type;
endpackage

// File: hdl/rtr_if.sv
// Valid/ready channel interfaces for the RGBA table resampler
interface rtr_req_if #(parameter int CHANNEL_BITS = 16);
   logic valid;
   logic ready;
   logic opcode;
   logic [7:0] entry_index;
   logic [CHANNEL_BITS-1:0] red_in;
   logic [CHANNEL_BITS-1:0] green_in;
   logic [CHANNEL_BITS-1:0] blue_in;
   logic [CHANNEL_BITS-1:0] alpha_in;
   modport source (output valid, opcode, entry_index, red_in, green_in, blue_in, alpha_in,
                   input ready);
   modport sink (input valid, opcode, entry_index, red_in, green_in, blue_in, alpha_in,
                 output ready);
endinterface

interface rtr_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] target_index;
   logic [15:0] red_out;
   logic [15:0] green_out;
   logic [15:0] blue_out;
   logic [15:0] alpha_out;
   logic last_entry;
   modport source (output valid, target_index, red_out, green_out, blue_out, alpha_out,
                   last_entry, input ready);
   modport sink (input valid, target_index, red_out, green_out, blue_out, alpha_out,
                 last_entry, output ready);
endinterface

interface rtr_csr_if;
   logic valid;
   logic ready;
   logic [1:0] index;
   logic [8:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/rgba_table_resampler.sv
// Top level: RGBA table resampler around one source table memory
// Write transfer: stored as the request is accepted. Pass-through: a table read, then ST_DONE. NB = CHANNEL_BITS+17.
// Upsample: two serial divider passes (position, then fraction), two table reads and a mix.
// Downsample: group length by division, a read and an accumulate per source entry, one
// divider pass per channel for the mean. A waiting result holds a request in ST_DONE.
// Synchronous active-high reset clears control; the table is undefined until written.
`include "rgba_table_resampler_defines.svh"
module rgba_table_resampler #(
   parameter int TABLE_DEPTH  = 256,
   parameter int CHANNEL_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   rtr_req_if.sink   req,
   rtr_rsp_if.source rsp,
   rtr_csr_if.sink   csr
);
   localparam int AW = (TABLE_DEPTH > 256) ? 8 : $clog2(TABLE_DEPTH);
   localparam int CB = CHANNEL_BITS;
   localparam int NB = 9 + CB + 8;
   localparam int SUMB = CB + 9;

   logic [4*CB-1:0] mem [TABLE_DEPTH];
   logic [4*CB-1:0] rd_data_ff;
   logic [AW-1:0]   rd_addr;
   logic            rd_en;

   rtr_pkg::state_type state_ff, state_in;
   logic [8:0] src_ff, tgt_ff, cur_ff, gstart_ff, sleft_ff, tleft_ff;
   logic [8:0] len_ff, j_ff, lo_ff, hi_ff;
   logic [15:0] frac_ff;
   logic [SUMB-1:0] sum_ff [4];
   logic [CB-1:0] a_ff [4];
   logic [1:0] ch_ff;
   logic       phase_ff;
   logic [CB-1:0] res_ff [4];
   logic [CB-1:0] out_ff [4];
   logic rsp_valid_ff;
   logic [7:0] rsp_idx_ff;
   logic rsp_last_ff;

   logic div_start, div_done;
   logic [NB-1:0] div_num, div_q;
   logic [8:0] div_den, div_r;

   function automatic logic [8:0] clamp(input logic [8:0] v);
      if (v == 9'd0) return 9'd1;
      if (32'(v) > TABLE_DEPTH) return 9'(TABLE_DEPTH);
      return v;
   endfunction

   rtr_divider #(.NUM_BITS(NB), .DEN_BITS(9)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .numerator(div_num),
      .denominator(div_den), .done(div_done), .quotient(div_q), .remainder(div_r));

   wire req_fire = req.valid && req.ready;
   wire csr_fire = csr.valid && csr.ready;
   wire in_range = 32'(req.entry_index) < TABLE_DEPTH;
   wire rsp_free = !rsp_valid_ff || rsp.ready;
   wire rsp_valid_in = ((state_ff == rtr_pkg::ST_DONE) && rsp_free) ||
                       (rsp_valid_ff && !rsp.ready);
   assign req.ready = (state_ff == rtr_pkg::ST_IDLE);
   assign csr.ready = (state_ff == rtr_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (req_fire && req.opcode == rtr_pkg::OP_WRITE && in_range)
         mem[req.entry_index[AW-1:0]] <= {req.alpha_in, req.blue_in, req.green_in, req.red_in};
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   wire [8:0] tl = (tleft_ff == 9'd0) ? 9'd1 : tleft_ff;
   wire [17:0] prod = cur_ff * (src_ff - 9'd1);
   wire [8:0] len_eff = (div_q[8:0] == 9'd0 && div_q[NB-1:9] == '0) ? 9'd1 : div_q[8:0];

   always_comb begin
      state_in = state_ff;
      div_start = 1'b0;
      div_num = '0;
      div_den = 9'd1;
      rd_en = 1'b0;
      rd_addr = '0;
      unique case (state_ff)
         rtr_pkg::ST_IDLE: if (req_fire && req.opcode == rtr_pkg::OP_NEXT)
            state_in = rtr_pkg::ST_MODE;
         rtr_pkg::ST_MODE: begin
            if (src_ff == tgt_ff) begin
               rd_en = 1'b1; rd_addr = cur_ff[AW-1:0];
               state_in = rtr_pkg::ST_DONE;
            end else begin
               div_start = 1'b1;
               div_num = (tgt_ff < src_ff) ? NB'(sleft_ff) : NB'(prod);
               div_den = (tgt_ff < src_ff) ? tl : tgt_ff;
               state_in = rtr_pkg::ST_DIV;
            end
         end
         rtr_pkg::ST_DIV: if (div_done)
            state_in = (tgt_ff < src_ff) ? rtr_pkg::ST_READ : rtr_pkg::ST_FRAC;
         rtr_pkg::ST_READ: begin
            rd_en = 1'b1;
            rd_addr = AW'(gstart_ff + j_ff);
            state_in = rtr_pkg::ST_ACC;
         end
         rtr_pkg::ST_ACC:
            state_in = (j_ff + 9'd1 == len_ff) ? rtr_pkg::ST_AVG : rtr_pkg::ST_READ;
         rtr_pkg::ST_AVG: begin
            if (!phase_ff) begin
               div_start = 1'b1;
               div_num = NB'(sum_ff[ch_ff]);
               div_den = len_ff;
            end else if (div_done && ch_ff == 2'd3) state_in = rtr_pkg::ST_DONE;
         end
         rtr_pkg::ST_FRAC: begin
            if (!phase_ff) begin
               div_start = 1'b1;
               div_num = NB'({div_r, 16'd0});
               div_den = tgt_ff;
            end else if (div_done) begin
               rd_en = 1'b1; rd_addr = lo_ff[AW-1:0];
               state_in = rtr_pkg::ST_MUL;
            end
         end
         rtr_pkg::ST_MUL: begin
            if (!phase_ff) begin
               rd_en = 1'b1; rd_addr = hi_ff[AW-1:0];
            end else if (ch_ff == 2'd3) state_in = rtr_pkg::ST_DONE;
         end
         rtr_pkg::ST_DONE: if (rsp_free) state_in = rtr_pkg::ST_IDLE;
         default: state_in = rtr_pkg::ST_IDLE;
      endcase
   end

   wire [CB+16:0] mix = a_ff[ch_ff] * (17'd65536 - {1'b0, frac_ff})
                      + rd_data_ff[ch_ff*CB +: CB] * {1'b0, frac_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtr_pkg::ST_IDLE;
         src_ff <= clamp(9'd256); tgt_ff <= clamp(9'd256);
         cur_ff <= '0; gstart_ff <= '0;
         sleft_ff <= clamp(9'd256); tleft_ff <= clamp(9'd256);
         rsp_valid_ff <= 1'b0;
         phase_ff <= 1'b0; ch_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_fire && (csr.index == rtr_pkg::REG_SOURCE_SIZE ||
                          csr.index == rtr_pkg::REG_TARGET_SIZE)) begin
            if (csr.index == rtr_pkg::REG_SOURCE_SIZE) begin
               src_ff <= clamp(csr.data); sleft_ff <= clamp(csr.data); tleft_ff <= tgt_ff;
            end else begin
               tgt_ff <= clamp(csr.data); tleft_ff <= clamp(csr.data); sleft_ff <= src_ff;
            end
            cur_ff <= '0; gstart_ff <= '0;
         end
         unique case (state_ff)
            rtr_pkg::ST_MODE: begin
               j_ff <= '0; ch_ff <= '0; phase_ff <= 1'b0;
               for (int c = 0; c < 4; c++) sum_ff[c] <= '0;
            end
            rtr_pkg::ST_DIV: if (div_done) begin
               if (tgt_ff < src_ff) len_ff <= len_eff;
               else begin
                  lo_ff <= div_q[8:0];
                  hi_ff <= (div_q[8:0] + 9'd1 < src_ff - 9'd1) ? div_q[8:0] + 9'd1
                                                              : src_ff - 9'd1;
               end
            end
            rtr_pkg::ST_ACC: begin
               for (int c = 0; c < 4; c++)
                  sum_ff[c] <= sum_ff[c] + SUMB'(rd_data_ff[c*CB +: CB]);
               j_ff <= j_ff + 9'd1;
            end
            rtr_pkg::ST_READ: if (j_ff == len_ff) j_ff <= j_ff;
            rtr_pkg::ST_AVG: begin
               if (!phase_ff) phase_ff <= 1'b1;
               else if (div_done) begin
                  res_ff[ch_ff] <= div_q[CB-1:0];
                  ch_ff <= ch_ff + 2'd1;
                  phase_ff <= 1'b0;
               end
            end
            rtr_pkg::ST_FRAC: begin
               if (!phase_ff) phase_ff <= 1'b1;
               else if (div_done) begin
                  frac_ff <= div_q[15:0]; phase_ff <= 1'b0;
               end
            end
            rtr_pkg::ST_MUL: begin
               if (!phase_ff) begin
                  for (int c = 0; c < 4; c++) a_ff[c] <= rd_data_ff[c*CB +: CB];
                  phase_ff <= 1'b1;
               end else begin
                  res_ff[ch_ff] <= mix[16 +: CB];
                  ch_ff <= ch_ff + 2'd1;
               end
            end
            rtr_pkg::ST_DONE: if (rsp_free) begin
               rsp_idx_ff <= cur_ff[7:0];
               rsp_last_ff <= (cur_ff + 9'd1 >= tgt_ff);
               for (int c = 0; c < 4; c++)
                  out_ff[c] <= (src_ff == tgt_ff) ? rd_data_ff[c*CB +: CB] : res_ff[c];
               if (cur_ff + 9'd1 >= tgt_ff) begin
                  cur_ff <= '0; gstart_ff <= '0; sleft_ff <= src_ff; tleft_ff <= tgt_ff;
               end else begin
                  cur_ff <= cur_ff + 9'd1;
                  if (tgt_ff < src_ff) begin
                     gstart_ff <= gstart_ff + len_ff;
                     sleft_ff <= (sleft_ff >= len_ff) ? sleft_ff - len_ff : 9'd0;
                     if (tleft_ff != 9'd0) tleft_ff <= tleft_ff - 9'd1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.target_index = rsp_idx_ff;
   assign rsp.red_out      = 16'(out_ff[0]);
   assign rsp.green_out    = 16'(out_ff[1]);
   assign rsp.blue_out     = 16'(out_ff[2]);
   assign rsp.alpha_out    = 16'(out_ff[3]);
   assign rsp.last_entry   = rsp_last_ff;

   `RTR_ASSERT_IMPL(a_no_accept_busy, clock, reset, state_ff != rtr_pkg::ST_IDLE, !req.ready)
   `RTR_ASSERT_NEXT(a_done_valid, clock, reset, state_ff == rtr_pkg::ST_DONE, rsp_valid_ff)
   `RTR_ASSERT_IMPL(a_cursor_range, clock, reset, 1'b1, cur_ff < tgt_ff)
endmodule

// File: hdl/rtr_divider.sv
// Restoring divider, one quotient bit per cycle
module rtr_divider #(
   parameter int NUM_BITS = 24,
   parameter int DEN_BITS = 9
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] numerator,
   input  logic [DEN_BITS-1:0] denominator,
   output logic                done,
   output logic [NUM_BITS-1:0] quotient,
   output logic [DEN_BITS-1:0] remainder
);
   localparam int CNT_BITS = $clog2(NUM_BITS + 1);
   logic [NUM_BITS-1:0] quot_ff, quot_in;
   logic [DEN_BITS:0]   rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;
   logic [DEN_BITS:0]   trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DEN_BITS-1:0], quot_ff[NUM_BITS-1]};
      if (start) begin
         quot_in = numerator;
         rem_in  = '0;
         cnt_in  = CNT_BITS'(NUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quot_in = {quot_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quot_in = {quot_ff[NUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      if (start) den_ff <= denominator;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff[DEN_BITS-1:0];
endmodule
